/* hw/rtl/sidta_pkg.sv */
`default_nettype none

package sidta_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned DigitWidth = 4;
  // 2^32 - 1 has ten decimal digits.
  localparam int unsigned DigitsMax  = 10;
  localparam int unsigned BcdWidth   = DigitsMax * DigitWidth;
  localparam int unsigned BitCntWidth   = $clog2(ValueWidth);
  localparam int unsigned DigitCntWidth = $clog2(DigitsMax);

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2D;

  // Commands from the sequencer to the converter.
  typedef struct packed {
    logic load;
    logic shift_digit;
  } conv_cmd_t;

  // Status from the converter to the sequencer.
  typedef struct packed {
    logic                  done;
    logic [DigitWidth-1:0] top_digit;
  } conv_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/sidta_bcd_conv.sv */
`default_nettype none

// Bit-serial binary to BCD converter (shift and add-3). One input bit enters
// the digit register per cycle, most significant bit first. After the
// conversion the digits are shifted out one at a time from the top.
module sidta_bcd_conv (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sidta_pkg::conv_cmd_t           cmd_i,
  input  wire logic [sidta_pkg::ValueWidth-1:0] mag_i,
  output sidta_pkg::conv_stat_t               stat_o
);

  logic [sidta_pkg::ValueWidth-1:0]  mag_q, mag_d;
  logic [sidta_pkg::BcdWidth-1:0]    bcd_q, bcd_d;
  logic [sidta_pkg::BcdWidth-1:0]    bcd_adj;
  logic [sidta_pkg::BitCntWidth-1:0] cnt_q, cnt_d;
  logic                              active_q, active_d;
  logic                              last_bit;

  assign last_bit = active_q &&
      (cnt_q == sidta_pkg::BitCntWidth'(sidta_pkg::ValueWidth - 1));

  // Every digit that is five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < sidta_pkg::DigitsMax; i++) begin
      if (bcd_q[i*sidta_pkg::DigitWidth +: sidta_pkg::DigitWidth] >= 4'd5) begin
        bcd_adj[i*sidta_pkg::DigitWidth +: sidta_pkg::DigitWidth] =
            bcd_q[i*sidta_pkg::DigitWidth +: sidta_pkg::DigitWidth] + 4'd3;
      end else begin
        bcd_adj[i*sidta_pkg::DigitWidth +: sidta_pkg::DigitWidth] =
            bcd_q[i*sidta_pkg::DigitWidth +: sidta_pkg::DigitWidth];
      end
    end
  end

  always_comb begin
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    if (cmd_i.load) begin
      mag_d    = mag_i;
      bcd_d    = '0;
      cnt_d    = '0;
      active_d = 1'b1;
    end else if (active_q) begin
      bcd_d    = {bcd_adj[sidta_pkg::BcdWidth-2:0], mag_q[sidta_pkg::ValueWidth-1]};
      mag_d    = {mag_q[sidta_pkg::ValueWidth-2:0], 1'b0};
      cnt_d    = cnt_q + 1'b1;
      active_d = !last_bit;
    end else if (cmd_i.shift_digit) begin
      bcd_d = {bcd_q[sidta_pkg::BcdWidth-sidta_pkg::DigitWidth-1:0],
               {sidta_pkg::DigitWidth{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.done      = last_bit;
  assign stat_o.top_digit =
      bcd_q[sidta_pkg::BcdWidth-1 -: sidta_pkg::DigitWidth];

endmodule

`default_nettype wire

/* hw/rtl/signed_int_to_decimal_ascii.sv */
`default_nettype none

// Converts a 32-bit two's-complement integer to its decimal ASCII text,
// most significant character first: a leading '-' for negative values, no
// leading zeros, a single '0' for zero, and -2147483648 handled in full.
// An item is taken when start is high while busy is low. The magnitude then
// runs through a bit-serial shift-and-add-3 converter, after which the sign
// is emitted (negative values only) and the ten BCD digits are scanned from
// the top, one digit per cycle; busy stays high throughout, and the next item
// can start on the cycle after busy falls. Each character appears on
// ascii_char_o for one cycle with strobe_o high, last_o marking the final one;
// the receiver cannot stall, so it must take every character in the cycle it
// is shown.
module signed_int_to_decimal_ascii (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [sidta_pkg::ValueWidth-1:0] value_i,
  output logic                                strobe_o,
  output logic [7:0]                          ascii_char_o,
  output logic                                last_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StSign = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e                              state_q, state_d;
  logic                                neg_q, neg_d;
  logic                                started_q, started_d;
  logic [sidta_pkg::DigitCntWidth-1:0] dcnt_q, dcnt_d;
  logic                                strobe_q, strobe_d;
  logic [7:0]                          char_q, char_d;
  logic                                last_q, last_d;

  sidta_pkg::conv_cmd_t                conv_cmd;
  sidta_pkg::conv_stat_t               conv_stat;
  logic [sidta_pkg::ValueWidth-1:0]    mag;
  logic                                accept;
  logic                                is_units;

  assign busy     = (state_q != StIdle);
  assign accept   = start && !busy;
  // Unsigned negation also gives the right magnitude for the most negative value.
  assign mag      = value_i[sidta_pkg::ValueWidth-1] ? (~value_i + 1'b1) : value_i;
  assign is_units = (dcnt_q == sidta_pkg::DigitCntWidth'(sidta_pkg::DigitsMax - 1));

  always_comb begin
    state_d          = state_q;
    neg_d            = neg_q;
    started_d        = started_q;
    dcnt_d           = dcnt_q;
    strobe_d         = 1'b0;
    char_d           = char_q;
    last_d           = last_q;
    conv_cmd.load        = 1'b0;
    conv_cmd.shift_digit = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          conv_cmd.load = 1'b1;
          neg_d         = value_i[sidta_pkg::ValueWidth-1];
          state_d       = StConv;
        end
      end
      StConv: begin
        if (conv_stat.done) begin
          started_d = 1'b0;
          dcnt_d    = '0;
          state_d   = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        strobe_d = 1'b1;
        char_d   = sidta_pkg::CharMinus;
        last_d   = 1'b0;
        state_d  = StEmit;
      end
      StEmit: begin
        // Leading zeros are skipped, but the units digit is always sent.
        if (conv_stat.top_digit != '0 || started_q || is_units) begin
          strobe_d  = 1'b1;
          char_d    = sidta_pkg::CharZero | {4'b0000, conv_stat.top_digit};
          last_d    = is_units;
          started_d = 1'b1;
        end
        conv_cmd.shift_digit = 1'b1;
        dcnt_d               = dcnt_q + 1'b1;
        if (is_units) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      neg_q     <= 1'b0;
      started_q <= 1'b0;
      dcnt_q    <= '0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      neg_q     <= neg_d;
      started_q <= started_d;
      dcnt_q    <= dcnt_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  sidta_bcd_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (conv_cmd),
    .mag_i  (mag),
    .stat_o (conv_stat)
  );

  assign strobe_o     = strobe_q;
  assign ascii_char_o = char_q;
  assign last_o       = last_q;

  // The block goes idle only in the same cycle that shows the final character.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $fell(busy) |-> strobe_o && last_o)
    else $error("busy fell without a final character");

  // A minus sign is never the final character.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
      strobe_o && (ascii_char_o == sidta_pkg::CharMinus) |-> !last_o)
    else $error("minus sign marked as last");

  // Every character is a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
      strobe_o |-> (ascii_char_o == sidta_pkg::CharMinus) ||
                   ((ascii_char_o >= sidta_pkg::CharZero) &&
                    (ascii_char_o <= sidta_pkg::CharNine)))
    else $error("illegal character emitted");

  // No character is shown just after an item is accepted, as its conversion begins.
  a_quiet_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
      accept |=> !strobe_o ##1 !strobe_o)
    else $error("character emitted during conversion");

endmodule

`default_nettype wire

/* dv/decimal_text_checker.sv */
`timescale 1ns / 1ps

module decimal_text_checker
  import sidta_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic [ValueWidth-1:0] value_i,
  input  wire logic                  strobe_o,
  input  wire logic [7:0]            ascii_char_o,
  input  wire logic                  last_o,
  output int unsigned                mismatch_count_o,
  output int unsigned                chars_pending_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  text_char_t  expected_chars[$];
  int unsigned mismatches;

  // Appends the decimal text of one item to the expected characters.
  function automatic void predict_text(input logic [ValueWidth-1:0] word);
    logic            negative;
    logic [ValueWidth-1:0] mag;
    logic [7:0]      digits[$];
    text_char_t      c;
    negative = word[ValueWidth-1];
    // Negation in unsigned 32-bit arithmetic also covers the most negative value.
    mag = negative ? (~word + 1'b1) : word;
    do begin
      digits.push_front(CharZero + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (negative) begin
      c.ch   = CharMinus;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    foreach (digits[i]) begin
      c.ch   = digits[i];
      c.last = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  initial mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      mismatch_count_o <= 0;
      chars_pending_o  <= 0;
    end else begin
      // A character can never belong to an item accepted at the same edge.
      if (strobe_o === 1'b1) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected character %h last %b", $realtime, ascii_char_o, last_o);
          end
        end else begin
          want = expected_chars.pop_front();
          if (ascii_char_o !== want.ch || last_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: character mismatch: expected %h last %b, got %h last %b",
                       $realtime, want.ch, want.last, ascii_char_o, last_o);
            end
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        predict_text(value_i);
      end
      mismatch_count_o <= mismatches;
      chars_pending_o  <= expected_chars.size();
    end
  end

endmodule

/* dv/signed_int_to_decimal_ascii_test.sv */
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;

  logic                             clk_i   = 1'b0;
  logic                             rst_ni  = 1'b0;
  logic                             start   = 1'b0;
  logic [sidta_pkg::ValueWidth-1:0] value_i = '0;
  logic                             busy;
  logic                             strobe_o;
  logic [7:0]                       ascii_char_o;
  logic                             last_o;
  int unsigned                      mismatch_count;
  int unsigned                      chars_pending;
  logic                             idle_en = 1'b1;

  int directed_values[$] = '{
    0, 1, -1, 7, -9, 9, 10, -10, 99, 100, -100, 999999999, 1000000000,
    -1000000000, 1234567890, -1234567890, 2147483647, -2147483647,
    32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 4294, -65536
  };

  always #5 clk_i = ~clk_i;

  signed_int_to_decimal_ascii u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .strobe_o     (strobe_o),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o)
  );

  decimal_text_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .value_i          (value_i),
    .strobe_o         (strobe_o),
    .ascii_char_o     (ascii_char_o),
    .last_o           (last_o),
    .mismatch_count_o (mismatch_count),
    .chars_pending_o  (chars_pending)
  );

  // Start stays high from one item to the next unless an idle gap comes between them.
  // An idle gap waits for the block to finish first, so that the gap is really seen.
  task automatic convert_value(input logic [sidta_pkg::ValueWidth-1:0] v);
    if (idle_en && $urandom_range(99) < 34) begin
      start   <= 1'b0;
      value_i <= $urandom;
      @(posedge clk_i);
      while (busy) begin
        value_i <= $urandom;
        @(posedge clk_i);
      end
      while ($urandom_range(99) < 34) begin
        value_i <= $urandom;
        @(posedge clk_i);
      end
    end
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [sidta_pkg::ValueWidth-1:0] random_value();
    logic [sidta_pkg::ValueWidth-1:0] v;
    logic [sidta_pkg::ValueWidth-1:0] p;
    p = 1;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(999);
      2: begin
        repeat ($urandom_range(9)) p = p * 10;
        v = p + $urandom_range(2) - 1;
      end
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1)) v = ~v + 1'b1;
    return v;
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_values[i]) convert_value(directed_values[i]);
    for (int n = 0; n < 450; n++) begin
      idle_en = !(n >= 200 && n < 300);
      convert_value(random_value());
    end
    start <= 1'b0;
    while (chars_pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("signed_int_to_decimal_ascii_test passed");
    end else begin
      $display("signed_int_to_decimal_ascii_test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("signed_int_to_decimal_ascii_test failed");
    $finish;
  end

endmodule
